// File: rtl/reader_writer_lock_arbiter_assert.svh
// assertion macros for the readers-writer lock arbiter
// expects clk_i and rst_ni in the scope of every use
`ifndef READER_WRITER_LOCK_ARBITER_ASSERT_SVH
`define READER_WRITER_LOCK_ARBITER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RWLA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RWLA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rwla_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the readers-writer lock arbiter
// no dependencies
package rwla_pkg;

  // defaults of the top level parameters
  localparam int unsigned QUEUE_DEPTH_DEF    = 16;
  localparam int unsigned THREAD_ID_BITS_DEF = 6;

  // fixed field widths of a transaction
  localparam int unsigned TID_FIELD_BITS = 6;
  localparam int unsigned RC_BITS        = 7;
  localparam logic [RC_BITS-1:0] READER_MAX = '1;

  // at most this many readers are woken by one writer exit
  localparam int unsigned MAX_WAKE  = 16;
  localparam int unsigned WAKE_BITS = $clog2(MAX_WAKE);

  typedef enum logic [1:0] {
    OP_ENTER_READ  = 2'd0,
    OP_ENTER_WRITE = 2'd1,
    OP_EXIT_READ   = 2'd2,
    OP_EXIT_WRITE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_GRANT   = 3'd0,
    KIND_QUEUED  = 3'd1,
    KIND_WOKEN   = 3'd2,
    KIND_NOTHING = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  typedef struct packed {
    op_e                       op;
    logic [TID_FIELD_BITS-1:0] thread_id;
  } req_t;

  typedef struct packed {
    kind_e                     kind;
    logic [TID_FIELD_BITS-1:0] grant_thread;
    logic                      grant_is_reader;
    logic                      last;
  } res_t;

endpackage

// File: rtl/rwla_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
module rwla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port, read returns the old contents on a collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/rwla_ctrl.sv
`timescale 1ns / 1ps
// lock state, queue pointers and sequencer of the readers-writer lock arbiter
// depends on rwla_pkg; drives the two wait queue rams
`include "reader_writer_lock_arbiter_assert.svh"
module rwla_ctrl #(
  parameter int unsigned QUEUE_DEPTH    = rwla_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned THREAD_ID_BITS = rwla_pkg::THREAD_ID_BITS_DEF,
  localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  rwla_pkg::req_t            in_data_i,
  output logic                      res_valid_o,
  output rwla_pkg::res_t            res_o,
  input  logic                      res_free_i,
  output logic                      rq_we_o,
  output logic [PTR_BITS-1:0]       rq_waddr_o,
  output logic [THREAD_ID_BITS-1:0] rq_wdata_o,
  output logic [PTR_BITS-1:0]       rq_raddr_o,
  input  logic [THREAD_ID_BITS-1:0] rq_rdata_i,
  output logic                      wq_we_o,
  output logic [PTR_BITS-1:0]       wq_waddr_o,
  output logic [THREAD_ID_BITS-1:0] wq_wdata_o,
  output logic [PTR_BITS-1:0]       wq_raddr_o,
  input  logic [THREAD_ID_BITS-1:0] wq_rdata_i
);
  import rwla_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN
  } state_e;

  state_e                    state_q, state_d;
  op_e                       op_q, op_d;
  logic [THREAD_ID_BITS-1:0] tid_q, tid_d;
  logic [RC_BITS-1:0]        rc_q, rc_d;
  logic                      wa_q, wa_d;
  logic [PTR_BITS-1:0]       r_head_q, r_head_d, r_tail_q, r_tail_d;
  logic [PTR_BITS-1:0]       w_head_q, w_head_d, w_tail_q, w_tail_d;
  logic [CNT_BITS-1:0]       r_cnt_q, r_cnt_d, w_cnt_q, w_cnt_d;
  logic [WAKE_BITS-1:0]      wake_n_q, wake_n_d;

  logic [THREAD_ID_BITS-1:0] tid_in;
  logic [THREAD_ID_BITS+TID_FIELD_BITS-1:0] tid_in_ext;
  logic [TID_FIELD_BITS-1:0] tid_q_f, rq_rd_f, wq_rd_f;
  logic [THREAD_ID_BITS+TID_FIELD_BITS-1:0] tid_q_ext, rq_rd_ext, wq_rd_ext;
  logic                      r_full, w_full, drain_last;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    ptr_inc = (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  // thread id width conversion between the fields and the stored ids
  assign tid_in_ext = {{THREAD_ID_BITS{1'b0}}, in_data_i.thread_id};
  assign tid_in     = tid_in_ext[THREAD_ID_BITS-1:0];
  assign tid_q_ext  = {{TID_FIELD_BITS{1'b0}}, tid_q};
  assign rq_rd_ext  = {{TID_FIELD_BITS{1'b0}}, rq_rdata_i};
  assign wq_rd_ext  = {{TID_FIELD_BITS{1'b0}}, wq_rdata_i};
  assign tid_q_f    = tid_q_ext[TID_FIELD_BITS-1:0];
  assign rq_rd_f    = rq_rd_ext[TID_FIELD_BITS-1:0];
  assign wq_rd_f    = wq_rd_ext[TID_FIELD_BITS-1:0];

  assign r_full     = (r_cnt_q == CNT_BITS'(QUEUE_DEPTH));
  assign w_full     = (w_cnt_q == CNT_BITS'(QUEUE_DEPTH));
  assign drain_last = (r_cnt_q == CNT_BITS'(1)) ||
                      (wake_n_q == WAKE_BITS'(MAX_WAKE - 1));

  // one transaction at a time
  assign in_stall_o = (state_q != ST_IDLE);

  // ram ports: writes at the tails, reads always follow the next head
  assign rq_waddr_o = r_tail_q;
  assign wq_waddr_o = w_tail_q;
  assign rq_wdata_o = tid_q;
  assign wq_wdata_o = tid_q;
  assign rq_raddr_o = r_head_d;
  assign wq_raddr_o = w_head_d;

  // sequencer and lock state update
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    tid_d       = tid_q;
    rc_d        = rc_q;
    wa_d        = wa_q;
    r_head_d    = r_head_q;
    r_tail_d    = r_tail_q;
    r_cnt_d     = r_cnt_q;
    w_head_d    = w_head_q;
    w_tail_d    = w_tail_q;
    w_cnt_d     = w_cnt_q;
    wake_n_d    = wake_n_q;
    rq_we_o     = 1'b0;
    wq_we_o     = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_data_i.op;
          tid_d   = tid_in;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (res_free_i) begin
          state_d              = ST_IDLE;
          res_o.last           = 1'b1;
          res_o.grant_thread   = tid_q_f;
          case (op_q)
            OP_ENTER_READ: begin
              res_valid_o           = 1'b1;
              res_o.grant_is_reader = 1'b1;
              if ((w_cnt_q != '0) || wa_q) begin
                if (r_full) begin
                  res_o.kind = KIND_ERROR;
                end else begin
                  rq_we_o    = 1'b1;
                  r_tail_d   = ptr_inc(r_tail_q);
                  r_cnt_d    = r_cnt_q + CNT_BITS'(1);
                  res_o.kind = KIND_QUEUED;
                end
              end else if (rc_q == READER_MAX) begin
                res_o.kind = KIND_ERROR;
              end else begin
                rc_d       = rc_q + RC_BITS'(1);
                res_o.kind = KIND_GRANT;
              end
            end
            OP_ENTER_WRITE: begin
              res_valid_o = 1'b1;
              if ((rc_q != '0) || wa_q) begin
                if (w_full) begin
                  res_o.kind = KIND_ERROR;
                end else begin
                  wq_we_o    = 1'b1;
                  w_tail_d   = ptr_inc(w_tail_q);
                  w_cnt_d    = w_cnt_q + CNT_BITS'(1);
                  res_o.kind = KIND_QUEUED;
                end
              end else begin
                wa_d       = 1'b1;
                res_o.kind = KIND_GRANT;
              end
            end
            OP_EXIT_READ: begin
              res_valid_o = 1'b1;
              if (rc_q == '0) begin
                res_o.kind            = KIND_ERROR;
                res_o.grant_is_reader = 1'b1;
              end else begin
                rc_d = rc_q - RC_BITS'(1);
                if ((rc_q == RC_BITS'(1)) && (w_cnt_q != '0)) begin
                  // last reader out hands the lock to the oldest writer
                  wa_d               = 1'b1;
                  w_head_d           = ptr_inc(w_head_q);
                  w_cnt_d            = w_cnt_q - CNT_BITS'(1);
                  res_o.kind         = KIND_WOKEN;
                  res_o.grant_thread = wq_rd_f;
                end else begin
                  res_o.kind         = KIND_NOTHING;
                  res_o.grant_thread = '0;
                end
              end
            end
            OP_EXIT_WRITE: begin
              if (!wa_q) begin
                res_valid_o = 1'b1;
                res_o.kind  = KIND_ERROR;
              end else if (r_cnt_q != '0) begin
                // waiting readers are released one per cycle while the output register is free
                wa_d     = 1'b0;
                wake_n_d = '0;
                state_d  = ST_DRAIN;
              end else if (w_cnt_q != '0) begin
                res_valid_o        = 1'b1;
                w_head_d           = ptr_inc(w_head_q);
                w_cnt_d            = w_cnt_q - CNT_BITS'(1);
                res_o.kind         = KIND_WOKEN;
                res_o.grant_thread = wq_rd_f;
              end else begin
                res_valid_o        = 1'b1;
                wa_d               = 1'b0;
                res_o.kind         = KIND_NOTHING;
                res_o.grant_thread = '0;
              end
            end
            default: begin
              res_valid_o = 1'b0;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (res_free_i) begin
          res_valid_o           = 1'b1;
          res_o.kind            = KIND_WOKEN;
          res_o.grant_thread    = rq_rd_f;
          res_o.grant_is_reader = 1'b1;
          res_o.last            = drain_last;
          r_head_d              = ptr_inc(r_head_q);
          r_cnt_d               = r_cnt_q - CNT_BITS'(1);
          wake_n_d              = wake_n_q + WAKE_BITS'(1);
          if (rc_q != READER_MAX) begin
            rc_d = rc_q + RC_BITS'(1);
          end
          if (drain_last) begin
            wake_n_d = '0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and lock registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_ENTER_READ;
      tid_q    <= '0;
      rc_q     <= '0;
      wa_q     <= 1'b0;
      r_head_q <= '0;
      r_tail_q <= '0;
      r_cnt_q  <= '0;
      w_head_q <= '0;
      w_tail_q <= '0;
      w_cnt_q  <= '0;
      wake_n_q <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      tid_q    <= tid_d;
      rc_q     <= rc_d;
      wa_q     <= wa_d;
      r_head_q <= r_head_d;
      r_tail_q <= r_tail_d;
      r_cnt_q  <= r_cnt_d;
      w_head_q <= w_head_d;
      w_tail_q <= w_tail_d;
      w_cnt_q  <= w_cnt_d;
      wake_n_q <= wake_n_d;
    end
  end

  // readers and a writer never hold the lock together
  `RWLA_ASSERT_IMP(a_excl, wa_q, rc_q == '0, "writer holds lock with readers active")
  // draining only while readers are queued
  `RWLA_ASSERT_IMP(a_drain_nonempty, state_q == ST_DRAIN, r_cnt_q != '0, "drain of empty queue")
  // a woken reader never sees the writer flag
  `RWLA_ASSERT_IMP(a_wake_rd, res_valid_o && res_o.kind == KIND_WOKEN && res_o.grant_is_reader,
                   !wa_q, "reader woken while writer flag set")
  // a woken writer owns the lock afterwards
  `RWLA_ASSERT_NXT(a_wake_wr, res_valid_o && res_o.kind == KIND_WOKEN && !res_o.grant_is_reader,
                   wa_q, "woken writer without writer flag")

endmodule

// File: rtl/reader_writer_lock_arbiter.sv
`timescale 1ns / 1ps
// readers-writer lock arbiter: an accepted transaction moves from idle to the exec state,
// which writes its result into the output register; a writer exit that wakes queued readers
// instead goes on to the drain state, which writes one result per cycle while the output is
// free, paced by the reader queue ram port; no new request is taken until the sequencer is
// back in idle, and output stalls hold it there; reset clears the reader count, writer flag and
// queue pointers at once, no clearing pass; top level over rwla_ctrl, rwla_ram and rwla_pkg
module reader_writer_lock_arbiter #(
  parameter int unsigned QUEUE_DEPTH    = rwla_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned THREAD_ID_BITS = rwla_pkg::THREAD_ID_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rwla_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rwla_pkg::res_t out_data_o
);
  import rwla_pkg::*;

  localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);

  logic                      res_valid, res_free;
  res_t                      res;
  logic                      out_valid_q;
  res_t                      out_q;
  logic                      rq_we, wq_we;
  logic [PTR_BITS-1:0]       rq_waddr, rq_raddr, wq_waddr, wq_raddr;
  logic [THREAD_ID_BITS-1:0] rq_wdata, rq_rdata, wq_wdata, wq_rdata;

  // sequencer
  rwla_ctrl #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .THREAD_ID_BITS(THREAD_ID_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_free_i (res_free),
    .rq_we_o    (rq_we),
    .rq_waddr_o (rq_waddr),
    .rq_wdata_o (rq_wdata),
    .rq_raddr_o (rq_raddr),
    .rq_rdata_i (rq_rdata),
    .wq_we_o    (wq_we),
    .wq_waddr_o (wq_waddr),
    .wq_wdata_o (wq_wdata),
    .wq_raddr_o (wq_raddr),
    .wq_rdata_i (wq_rdata)
  );

  // reader wait queue
  rwla_ram #(
    .WIDTH(THREAD_ID_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_rq_ram (
    .clk_i  (clk_i),
    .we_i   (rq_we),
    .waddr_i(rq_waddr),
    .wdata_i(rq_wdata),
    .raddr_i(rq_raddr),
    .rdata_o(rq_rdata)
  );

  // writer wait queue
  rwla_ram #(
    .WIDTH(THREAD_ID_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_wq_ram (
    .clk_i  (clk_i),
    .we_i   (wq_we),
    .waddr_i(wq_waddr),
    .wdata_i(wq_wdata),
    .raddr_i(wq_raddr),
    .rdata_o(wq_rdata)
  );

  // output register, refilled in the cycle its transaction leaves
  assign res_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: test/reader_writer_lock_arbiter_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the readers-writer lock arbiter: directed and random lock traffic
// against an in-bench predictor, with random source gaps and sink stalls
// depends on rwla_pkg and reader_writer_lock_arbiter
module reader_writer_lock_arbiter_tb;
  import rwla_pkg::*;

  localparam int unsigned QD      = QUEUE_DEPTH_DEF;
  // two copies of the lock state: one shapes the stimulus, one predicts results
  localparam int          GEN     = 0;
  localparam int          CHK     = 1;
  localparam bit          READ_Q  = 1'b1;
  localparam bit          WRITE_Q = 1'b0;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  res_t out_data_o;

  // lock state per copy
  int unsigned readers     [2];
  bit          writer_held [2];
  logic [5:0]  wait_slot   [2][2][QD];
  int unsigned wait_head   [2][2];
  int unsigned wait_cnt    [2][2];

  res_t lock_results[$];
  req_t lock_requests[$];
  res_t due_results[$];

  int idle_pct     = 0;
  int stall_pct    = 0;
  int issued_cnt   = 0;
  int accepted_cnt = 0;
  int checked_cnt  = 0;
  int fail_cnt     = 0;
  int widest_burst = 0;
  int kind_seen[5] = '{0, 0, 0, 0, 0};

  reader_writer_lock_arbiter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results still due", $time, due_results.size());
    $display("reader_writer_lock_arbiter_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // lock predictor
  // ---------------------------------------------------------------------------

  function automatic void lock_clear(int c);
    readers[c]     = 0;
    writer_held[c] = 1'b0;
    for (int q = 0; q < 2; q++) begin
      wait_head[c][q] = 0;
      wait_cnt[c][q]  = 0;
    end
  endfunction

  function automatic bit wait_push(int c, bit q, logic [5:0] tid);
    if (wait_cnt[c][q] >= QD) return 1'b0;
    wait_slot[c][q][(wait_head[c][q] + wait_cnt[c][q]) % QD] = tid;
    wait_cnt[c][q]++;
    return 1'b1;
  endfunction

  function automatic logic [5:0] wait_pop(int c, bit q);
    logic [5:0] tid;
    tid = wait_slot[c][q][wait_head[c][q]];
    wait_head[c][q] = (wait_head[c][q] + 1) % QD;
    wait_cnt[c][q]--;
    return tid;
  endfunction

  function automatic void add_result(kind_e k, logic [5:0] tid, bit is_reader);
    res_t r;
    r.kind            = k;
    r.grant_thread    = tid;
    r.grant_is_reader = is_reader;
    r.last            = 1'b0;
    lock_results.push_back(r);
  endfunction

  // applies one request to copy c, leaving its results in lock_results
  function automatic void apply_lock_op(int c, req_t r);
    res_t tail_res;
    lock_results.delete();
    case (r.op)
      OP_ENTER_READ: begin
        if (wait_cnt[c][WRITE_Q] > 0 || writer_held[c]) begin
          if (wait_push(c, READ_Q, r.thread_id)) add_result(KIND_QUEUED, r.thread_id, 1'b1);
          else add_result(KIND_ERROR, r.thread_id, 1'b1);
        end else if (readers[c] >= READER_MAX) begin
          add_result(KIND_ERROR, r.thread_id, 1'b1);
        end else begin
          readers[c]++;
          add_result(KIND_GRANT, r.thread_id, 1'b1);
        end
      end
      OP_ENTER_WRITE: begin
        if (readers[c] > 0 || writer_held[c]) begin
          if (wait_push(c, WRITE_Q, r.thread_id)) add_result(KIND_QUEUED, r.thread_id, 1'b0);
          else add_result(KIND_ERROR, r.thread_id, 1'b0);
        end else begin
          writer_held[c] = 1'b1;
          add_result(KIND_GRANT, r.thread_id, 1'b0);
        end
      end
      OP_EXIT_READ: begin
        if (readers[c] == 0) begin
          add_result(KIND_ERROR, r.thread_id, 1'b1);
        end else begin
          readers[c]--;
          // last reader out hands the lock to the oldest waiting writer
          if (readers[c] == 0 && wait_cnt[c][WRITE_Q] > 0) begin
            writer_held[c] = 1'b1;
            add_result(KIND_WOKEN, wait_pop(c, WRITE_Q), 1'b0);
          end else begin
            add_result(KIND_NOTHING, '0, 1'b0);
          end
        end
      end
      default: begin
        if (!writer_held[c]) begin
          add_result(KIND_ERROR, r.thread_id, 1'b0);
        end else if (wait_cnt[c][READ_Q] > 0) begin
          // waiting readers take precedence, woken in arrival order
          writer_held[c] = 1'b0;
          while (wait_cnt[c][READ_Q] > 0 && lock_results.size() < MAX_WAKE) begin
            if (readers[c] < READER_MAX) readers[c]++;
            add_result(KIND_WOKEN, wait_pop(c, READ_Q), 1'b1);
          end
        end else if (wait_cnt[c][WRITE_Q] > 0) begin
          // lock passes straight to the next writer, flag stays set
          add_result(KIND_WOKEN, wait_pop(c, WRITE_Q), 1'b0);
        end else begin
          writer_held[c] = 1'b0;
          add_result(KIND_NOTHING, '0, 1'b0);
        end
      end
    endcase
    tail_res      = lock_results.pop_back();
    tail_res.last = 1'b1;
    lock_results.push_back(tail_res);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus shaping
  // ---------------------------------------------------------------------------

  function automatic logic [5:0] rand_tid();
    return 6'($urandom_range(63));
  endfunction

  task automatic issue(op_e op, logic [5:0] tid);
    req_t r;
    r.op        = op;
    r.thread_id = tid;
    apply_lock_op(GEN, r);
    lock_requests.push_back(r);
    issued_cnt++;
  endtask

  // releases every holder so the lock ends up free with empty queues
  task automatic drain_lock();
    for (int k = 0; k < 1000; k++) begin
      if (readers[GEN] == 0 && !writer_held[GEN] && wait_cnt[GEN][READ_Q] == 0 &&
          wait_cnt[GEN][WRITE_Q] == 0) break;
      if (writer_held[GEN]) issue(OP_EXIT_WRITE, rand_tid());
      else issue(OP_EXIT_READ, rand_tid());
    end
  endtask

  task automatic random_burst();
    int n;
    case ($urandom_range(9))
      // short reader session, sometimes with a writer arriving mid-way
      0, 1, 2: begin
        n = $urandom_range(1, 5);
        repeat (n) issue(OP_ENTER_READ, rand_tid());
        if ($urandom_range(1)) issue(OP_ENTER_WRITE, rand_tid());
        repeat (n) issue(OP_EXIT_READ, rand_tid());
      end
      // writer holds the lock while readers pile up, at times past a full queue
      3, 4, 5: begin
        n = ($urandom_range(3) == 0) ? QD + 1 : $urandom_range(0, 4);
        issue(OP_ENTER_WRITE, rand_tid());
        repeat (n) issue(OP_ENTER_READ, rand_tid());
        if ($urandom_range(1)) issue(OP_ENTER_WRITE, rand_tid());
        issue(OP_EXIT_WRITE, rand_tid());
      end
      // reader holds the lock while writers pile up
      6: begin
        n = ($urandom_range(3) == 0) ? QD + 1 : $urandom_range(1, 4);
        issue(OP_ENTER_READ, rand_tid());
        repeat (n) issue(OP_ENTER_WRITE, rand_tid());
        issue(OP_EXIT_READ, rand_tid());
      end
      // unstructured traffic
      default: begin
        repeat ($urandom_range(1, 3)) issue(op_e'($urandom_range(3)), rand_tid());
      end
    endcase
    if ($urandom_range(1)) drain_lock();
  endtask

  // holds off until every request is taken and every result has come back
  task automatic settle();
    while (accepted_cnt != issued_cnt || due_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // driver, sink stall and monitor
  // ---------------------------------------------------------------------------

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_lock_op(CHK, in_data_i);
        foreach (lock_results[i]) due_results.push_back(lock_results[i]);
        if (lock_results.size() > widest_burst) widest_burst = lock_results.size();
        accepted_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (lock_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= lock_requests.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result sink stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    fail_cnt++;
  endtask

  // result monitor
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d thread %0d reader %0b last %0b",
                 $time, out_data_o.kind, out_data_o.grant_thread, out_data_o.grant_is_reader,
                 out_data_o.last);
        fail_cnt++;
      end else begin
        want = due_results.pop_front();
        if (out_data_o.kind !== want.kind)
          report_field("kind", 8'(want.kind), 8'(out_data_o.kind));
        if (out_data_o.grant_thread !== want.grant_thread)
          report_field("grant_thread", 8'(want.grant_thread), 8'(out_data_o.grant_thread));
        if (out_data_o.grant_is_reader !== want.grant_is_reader)
          report_field("grant_is_reader", 8'(want.grant_is_reader),
                       8'(out_data_o.grant_is_reader));
        if (out_data_o.last !== want.last)
          report_field("last", 8'(want.last), 8'(out_data_o.last));
        kind_seen[want.kind]++;
        checked_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int idle_plan[4];
    int stall_plan[4];
    int phase_start;
    idle_plan  = '{0, 70, 0, 13};
    stall_plan = '{0, 0, 70, 13};
    lock_clear(GEN);
    lock_clear(CHK);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: exits with no holder, extreme ids, hand-overs in every direction
    issue(OP_EXIT_READ,   6'd63);
    issue(OP_EXIT_WRITE,  6'd0);
    issue(OP_ENTER_READ,  6'd0);
    issue(OP_ENTER_READ,  6'd63);
    issue(OP_EXIT_READ,   6'd0);
    issue(OP_ENTER_WRITE, 6'd21);
    issue(OP_ENTER_READ,  6'd42);
    issue(OP_EXIT_READ,   6'd63);
    issue(OP_ENTER_WRITE, 6'd5);
    issue(OP_EXIT_WRITE,  6'd21);
    issue(OP_EXIT_READ,   6'd42);
    issue(OP_ENTER_WRITE, 6'd7);
    issue(OP_EXIT_WRITE,  6'd5);
    issue(OP_EXIT_WRITE,  6'd7);
    issue(OP_ENTER_WRITE, 6'd63);
    issue(OP_ENTER_WRITE, 6'd0);
    issue(OP_EXIT_WRITE,  6'd63);
    issue(OP_EXIT_WRITE,  6'd0);
    issue(OP_EXIT_WRITE,  6'd42);
    settle();

    // random traffic under each idling pattern, pausing for results between phases
    for (int p = 0; p < 4; p++) begin
      idle_pct    = idle_plan[p];
      stall_pct   = stall_plan[p];
      phase_start = issued_cnt;
      while (issued_cnt < phase_start + 30) random_burst();
      drain_lock();
      settle();
    end

    // reader flood one past the reader count ceiling; the lock is left held
    repeat (READER_MAX + 1) issue(OP_ENTER_READ, rand_tid());
    issue(OP_ENTER_WRITE, rand_tid());
    settle();

    repeat (20) @(posedge clk_i);
    $display("%0d lock requests accepted, %0d results checked, largest burst %0d results",
             accepted_cnt, checked_cnt, widest_burst);
    $display("grants %0d, queued %0d, woken %0d, nothing %0d, errors %0d",
             kind_seen[KIND_GRANT], kind_seen[KIND_QUEUED], kind_seen[KIND_WOKEN],
             kind_seen[KIND_NOTHING], kind_seen[KIND_ERROR]);
    if (fail_cnt == 0 && due_results.size() == 0) begin
      $display("reader_writer_lock_arbiter_tb OK");
    end else begin
      $display("reader_writer_lock_arbiter_tb NOT OK");
    end
    $finish;
  end

endmodule
